// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tmse_pkg.sv =====
`default_nettype none

package tmse_pkg;

	// Default geometry
	localparam int TAPE_CELLS_DEF   = 1024;
	localparam int STATE_COUNT_DEF  = 64;
	localparam int SYMBOL_COUNT_DEF = 8;

	// Field widths
	localparam int CMD_W      = 2;
	localparam int STATE_W    = 6;
	localparam int SYM_W      = 3;
	localparam int MOVE_W     = 2;
	localparam int ADDR_W     = 10;
	localparam int TIME_W     = 16;
	localparam int ACC_W      = 17;
	localparam int ERR_W      = 2;
	localparam int COUNT_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 56;
	localparam int M_TDATA_W  = 56;

	// Commands
	localparam logic [CMD_W-1:0] CMD_LOAD_RULE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_CELL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TICK      = 2'd3;

	// Head moves
	localparam logic [MOVE_W-1:0] MOVE_NONE    = 2'd0;
	localparam logic [MOVE_W-1:0] MOVE_LEFT    = 2'd1;
	localparam logic [MOVE_W-1:0] MOVE_RIGHT   = 2'd2;
	localparam logic [MOVE_W-1:0] MOVE_INVALID = 2'd3;

	// Run error codes
	localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_NO_RULE = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EDGE    = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_HEAD  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALT_STATE  = 2'd3;

	// Configuration reset values
	localparam logic [TIME_W-1:0]  STEP_PERIOD_RST = 16'd100;
	localparam logic [STATE_W-1:0] START_STATE_RST = 6'd0;
	localparam logic [ADDR_W-1:0]  START_HEAD_RST  = 10'd0;
	localparam logic [STATE_W-1:0] HALT_STATE_RST  = 6'd63;

	// One transition rule as stored in the rule memory
	typedef struct packed {
		logic               valid;
		logic [SYM_W-1:0]   write_sym;
		logic [MOVE_W-1:0]  move;
		logic [STATE_W-1:0] next_state;
	} rule_entry_t;

endpackage

`default_nettype wire

// ===== sv/tmse_ram.sv =====
`default_nettype none

// Simple dual-port synchronous RAM with registered read, write-first
// when a read and a write hit the same entry on the same edge.
module tmse_ram #(
	parameter int WIDTH = tmse_pkg::SYM_W,
	parameter int DEPTH = tmse_pkg::TAPE_CELLS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, forward a same-edge write
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/turing_machine_step_engine_core.sv =====
// From input beat to result beat the item passes ST_EXEC (rule read) and ST_FIN (tape read
// at new head); the result beat is registered. No new beat is taken while one is in ST_EXEC.
// A stalled output holds the engine in its final cycle; the next beat is taken with it.
// Reset: asynchronous, active low; afterwards a clearing pass over max(TAPE_CELLS,
// STATE_COUNT*SYMBOL_COUNT) entries (1024 by default) blanks the tape and invalidates
// all rules; no input beat is taken during it, configuration writes are.
`default_nettype none

module turing_machine_step_engine_core #(
	parameter int TAPE_CELLS   = tmse_pkg::TAPE_CELLS_DEF,
	parameter int STATE_COUNT  = tmse_pkg::STATE_COUNT_DEF,
	parameter int SYMBOL_COUNT = tmse_pkg::SYMBOL_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave side
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// rule_state, rule_read_symbol, rule_write_symbol, rule_move, rule_next_state,
	// cell_address, cell_symbol, elapsed, zero pad
	input  logic [tmse_pkg::S_TDATA_W-1:0]   s_tdata,
	// cmd
	input  logic [tmse_pkg::CMD_W-1:0]       s_tuser,
	// master side
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// running, stepped, error, head_position, current_state, symbol_under_head,
	// step_total, zero pad
	output logic [tmse_pkg::M_TDATA_W-1:0]   m_tdata,
	// configuration
	input  logic                             cfg_we,
	input  logic [tmse_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tmse_pkg::CFG_DATA_W-1:0]  cfg_data
);

	`include "assert_macros.svh"

	localparam int HW         = $clog2(TAPE_CELLS);
	localparam int RULE_SLOTS = STATE_COUNT * SYMBOL_COUNT;
	localparam int RW         = $clog2(RULE_SLOTS);
	localparam int CLR_N      = (TAPE_CELLS > RULE_SLOTS) ? TAPE_CELLS : RULE_SLOTS;
	localparam int CW         = $clog2(CLR_N);
	localparam int RULE_BITS  = $bits(tmse_pkg::rule_entry_t);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_FIN} fsm_t;

	fsm_t state_q;
	logic [CW-1:0] clr_q;

	// configuration registers
	logic [tmse_pkg::TIME_W-1:0]  step_period_q;
	logic [tmse_pkg::STATE_W-1:0] start_state_q;
	logic [tmse_pkg::ADDR_W-1:0]  start_head_q;
	logic [tmse_pkg::STATE_W-1:0] halt_state_q;

	// machine state
	logic [HW-1:0]                 head_q;
	logic [tmse_pkg::STATE_W-1:0]  mstate_q;
	logic [tmse_pkg::ACC_W-1:0]    acc_q;
	logic [tmse_pkg::COUNT_W-1:0]  count_q;
	logic                          run_q;
	logic [tmse_pkg::ERR_W-1:0]    err_q;

	// item captured at accept
	logic [tmse_pkg::CMD_W-1:0]    cmd_s1;
	logic [tmse_pkg::STATE_W-1:0]  rstate_s1;
	logic [tmse_pkg::SYM_W-1:0]    rread_s1;
	logic [tmse_pkg::SYM_W-1:0]    rwrite_s1;
	logic [tmse_pkg::MOVE_W-1:0]   rmove_s1;
	logic [tmse_pkg::STATE_W-1:0]  rnext_s1;
	logic [tmse_pkg::ADDR_W-1:0]   caddr_s1;
	logic [tmse_pkg::SYM_W-1:0]    csym_s1;
	logic [tmse_pkg::TIME_W-1:0]   elapsed_s1;
	logic [RW-1:0]                 ridx_s1;
	logic                          stepped_s2;

	// input fields
	logic [tmse_pkg::STATE_W-1:0]  in_rstate;
	logic [tmse_pkg::SYM_W-1:0]    in_rread;
	logic [tmse_pkg::SYM_W-1:0]    in_rwrite;
	logic [tmse_pkg::MOVE_W-1:0]   in_rmove;
	logic [tmse_pkg::STATE_W-1:0]  in_rnext;
	logic [tmse_pkg::ADDR_W-1:0]   in_caddr;
	logic [tmse_pkg::SYM_W-1:0]    in_csym;
	logic [tmse_pkg::TIME_W-1:0]   in_elapsed;

	// handshake
	logic in_acc;
	logic out_free;
	logic out_load;
	logic clr_done;

	// memory ports
	logic                       tape_we;
	logic [HW-1:0]              tape_waddr;
	logic [tmse_pkg::SYM_W-1:0] tape_wdata;
	logic                       tape_re;
	logic [HW-1:0]              tape_raddr;
	logic [tmse_pkg::SYM_W-1:0] tape_rdata;
	logic                       rule_we;
	logic [RW-1:0]              rule_waddr;
	logic [RULE_BITS-1:0]       rule_wdata;
	logic                       rule_re;
	logic [RW-1:0]              rule_raddr;
	logic [RULE_BITS-1:0]       rule_rdata;

	// execute-cycle results
	tmse_pkg::rule_entry_t         rr;
	tmse_pkg::rule_entry_t         new_rule;
	logic [HW-1:0]                 ex_head;
	logic [tmse_pkg::STATE_W-1:0]  ex_mstate;
	logic [tmse_pkg::ACC_W-1:0]    ex_acc;
	logic [tmse_pkg::COUNT_W-1:0]  ex_count;
	logic                          ex_run;
	logic [tmse_pkg::ERR_W-1:0]    ex_err;
	logic                          ex_stepped;
	logic                          ex_tape_we;
	logic [HW-1:0]                 ex_tape_waddr;
	logic [tmse_pkg::SYM_W-1:0]    ex_tape_wdata;
	logic                          ex_rule_we;

	function automatic logic [RW-1:0] rule_idx(input logic [tmse_pkg::STATE_W-1:0] st,
		input logic [tmse_pkg::SYM_W-1:0] sym);
		int t;
		t = int'(st) * SYMBOL_COUNT + int'(sym);
		return RW'(t);
	endfunction

	// unpack the input beat
	assign in_rstate  = s_tdata[5:0];
	assign in_rread   = s_tdata[8:6];
	assign in_rwrite  = s_tdata[11:9];
	assign in_rmove   = s_tdata[13:12];
	assign in_rnext   = s_tdata[19:14];
	assign in_caddr   = s_tdata[29:20];
	assign in_csym    = s_tdata[32:30];
	assign in_elapsed = s_tdata[48:33];

	// handshake
	assign out_free = !m_tvalid || m_tready;
	assign out_load = (state_q == ST_FIN) && out_free;
	assign s_tready = (state_q == ST_IDLE) || out_load;
	assign in_acc   = s_tvalid && s_tready;
	assign clr_done = (clr_q == CW'(CLR_N - 1));

	// rule lookup at accept: rule slot for loads, current state and symbol under head otherwise
	assign rule_re    = in_acc;
	assign rule_raddr = (s_tuser == tmse_pkg::CMD_LOAD_RULE) ? rule_idx(in_rstate, in_rread)
		: rule_idx(mstate_q, tape_rdata);

	// apply the item once the rule is back
	always_comb begin
		rr            = tmse_pkg::rule_entry_t'(rule_rdata);
		new_rule      = '{valid: 1'b1, write_sym: rwrite_s1, move: rmove_s1,
			next_state: rnext_s1};
		ex_head       = head_q;
		ex_mstate     = mstate_q;
		ex_acc        = acc_q;
		ex_count      = count_q;
		ex_run        = run_q;
		ex_err        = err_q;
		ex_stepped    = 1'b0;
		ex_tape_we    = 1'b0;
		ex_tape_waddr = head_q;
		ex_tape_wdata = rr.write_sym;
		ex_rule_we    = 1'b0;
		unique case (cmd_s1)
			tmse_pkg::CMD_LOAD_RULE: begin
				if ((int'(rstate_s1) < STATE_COUNT) && (int'(rread_s1) < SYMBOL_COUNT)
						&& (int'(rwrite_s1) < SYMBOL_COUNT) && (int'(rnext_s1) < STATE_COUNT)
						&& (rmove_s1 != tmse_pkg::MOVE_INVALID) && !rr.valid) begin
					ex_rule_we = 1'b1;
				end
			end
			tmse_pkg::CMD_LOAD_CELL: begin
				if ((int'(caddr_s1) < TAPE_CELLS) && (int'(csym_s1) < SYMBOL_COUNT)) begin
					ex_tape_we    = 1'b1;
					ex_tape_waddr = HW'(caddr_s1);
					ex_tape_wdata = csym_s1;
				end
			end
			tmse_pkg::CMD_START: begin
				ex_mstate = start_state_q;
				if (int'(start_head_q) < TAPE_CELLS) begin
					ex_head = HW'(start_head_q);
				end else begin
					ex_head = HW'(TAPE_CELLS - 1);
				end
				ex_acc   = '0;
				ex_count = '0;
				ex_err   = tmse_pkg::ERR_NONE;
				ex_run   = (start_state_q != halt_state_q);
			end
			tmse_pkg::CMD_TICK: begin
				if (run_q) begin
					if (acc_q < {1'b0, step_period_q}) begin
						ex_acc = acc_q + {1'b0, elapsed_s1};
					end else begin
						ex_acc = '0;
						if ((int'(mstate_q) >= STATE_COUNT) || !rr.valid) begin
							ex_err = tmse_pkg::ERR_NO_RULE;
							ex_run = 1'b0;
						end else begin
							ex_tape_we = 1'b1;
							// move the head, stop at either tape end
							if (rr.move == tmse_pkg::MOVE_LEFT) begin
								if (head_q == '0) begin
									ex_err = tmse_pkg::ERR_EDGE;
									ex_run = 1'b0;
								end else begin
									ex_head = head_q - 1'b1;
								end
							end else if (rr.move == tmse_pkg::MOVE_RIGHT) begin
								if (head_q == HW'(TAPE_CELLS - 1)) begin
									ex_err = tmse_pkg::ERR_EDGE;
									ex_run = 1'b0;
								end else begin
									ex_head = head_q + 1'b1;
								end
							end
							ex_mstate  = rr.next_state;
							ex_stepped = 1'b1;
							if (count_q != '1) begin
								ex_count = count_q + 1'b1;
							end
							if (rr.next_state == halt_state_q) begin
								ex_run = 1'b0;
							end
						end
					end
				end
			end
		endcase
	end

	// memory port muxing: clearing sweep or execute cycle
	always_comb begin
		tape_we    = 1'b0;
		tape_waddr = ex_tape_waddr;
		tape_wdata = ex_tape_wdata;
		tape_re    = 1'b0;
		tape_raddr = ex_head;
		rule_we    = 1'b0;
		rule_waddr = ridx_s1;
		rule_wdata = new_rule;
		if (state_q == ST_CLEAR) begin
			tape_we    = (int'(clr_q) < TAPE_CELLS);
			tape_waddr = HW'(clr_q);
			tape_wdata = '0;
			tape_re    = 1'b1;
			tape_raddr = head_q;
			rule_we    = (int'(clr_q) < RULE_SLOTS);
			rule_waddr = RW'(clr_q);
			rule_wdata = '0;
		end else if (state_q == ST_EXEC) begin
			tape_we = ex_tape_we;
			tape_re = 1'b1;
			rule_we = ex_rule_we;
		end
	end

	tmse_ram #(
		.WIDTH(tmse_pkg::SYM_W),
		.DEPTH(TAPE_CELLS)
	) u_tape (
		.clk  (clk),
		.we   (tape_we),
		.waddr(tape_waddr),
		.wdata(tape_wdata),
		.re   (tape_re),
		.raddr(tape_raddr),
		.rdata(tape_rdata)
	);

	tmse_ram #(
		.WIDTH(RULE_BITS),
		.DEPTH(RULE_SLOTS)
	) u_rules (
		.clk  (clk),
		.we   (rule_we),
		.waddr(rule_waddr),
		.wdata(rule_wdata),
		.re   (rule_re),
		.raddr(rule_raddr),
		.rdata(rule_rdata)
	);

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= in_acc ? ST_EXEC : ST_IDLE;
					end
				end
			endcase
		end
	end

	// machine state, updated in the execute cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			mstate_q <= '0;
			acc_q    <= '0;
			count_q  <= '0;
			run_q    <= 1'b0;
			err_q    <= tmse_pkg::ERR_NONE;
		end else if (state_q == ST_EXEC) begin
			head_q   <= ex_head;
			mstate_q <= ex_mstate;
			acc_q    <= ex_acc;
			count_q  <= ex_count;
			run_q    <= ex_run;
			err_q    <= ex_err;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_period_q <= tmse_pkg::STEP_PERIOD_RST;
			start_state_q <= tmse_pkg::START_STATE_RST;
			start_head_q  <= tmse_pkg::START_HEAD_RST;
			halt_state_q  <= tmse_pkg::HALT_STATE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tmse_pkg::REG_STEP_PERIOD: step_period_q <= cfg_data;
				tmse_pkg::REG_START_STATE: start_state_q <= cfg_data[tmse_pkg::STATE_W-1:0];
				tmse_pkg::REG_START_HEAD:  start_head_q  <= cfg_data[tmse_pkg::ADDR_W-1:0];
				tmse_pkg::REG_HALT_STATE:  halt_state_q  <= cfg_data[tmse_pkg::STATE_W-1:0];
			endcase
		end
	end

	// capture the accepted beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1     <= s_tuser;
			rstate_s1  <= in_rstate;
			rread_s1   <= in_rread;
			rwrite_s1  <= in_rwrite;
			rmove_s1   <= in_rmove;
			rnext_s1   <= in_rnext;
			caddr_s1   <= in_caddr;
			csym_s1    <= in_csym;
			elapsed_s1 <= in_elapsed;
			ridx_s1    <= rule_idx(in_rstate, in_rread);
		end
		if (state_q == ST_EXEC) begin
			stepped_s2 <= ex_stepped;
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {1'b0, count_q, tape_rdata, mstate_q, tmse_pkg::ADDR_W'(head_q),
				err_q, stepped_s2, run_q};
		end
	end

	`ASSERT_IMPLY(a_head_on_tape, 1'b1, int'(head_q) < TAPE_CELLS, "head left the tape")
	`ASSERT_NEXT(a_accept_exec, in_acc, state_q == ST_EXEC, "accepted beat not executed")
	`ASSERT_IMPLY(a_step_has_rule, m_tvalid && m_tdata[1], m_tdata[3:2] != tmse_pkg::ERR_NO_RULE, "step reported with missing rule")

endmodule

`default_nettype wire
